/* rtl/bdb_pkg.sv */
// ----------------------------------------------------------------------------
// bdb_pkg
// shared widths, codes and types of the gbrg bilinear demosaic block
// ----------------------------------------------------------------------------
`default_nettype none

package bdb_pkg;

  localparam int PixW       = 8;
  localparam int CfgW       = 11;
  localparam int CfgIndexW  = 1;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  localparam logic [CfgW-1:0] DimReset = 11'd1024;

  typedef enum logic [CfgIndexW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // per-word site information, fixed at accept time
  typedef struct packed {
    logic emit;
    logic col0;
    logic x_odd;
    logic y_odd;
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } site_t;

endpackage

`default_nettype wire

/* rtl/bilinear_debayer_gbrg.sv */
// ----------------------------------------------------------------------------
// bilinear_debayer_gbrg
// bilinear demosaic of a gbrg bayer stream into rgb pixels
// ----------------------------------------------------------------------------
// Takes one 8-bit Bayer word per cycle in raster order (even rows G B, odd
// rows R G) and gives one RGB word per site, sustaining one word per cycle
// with no gaps while the output is not stalled: the line memory has one
// read and one write port, each word is held in one stage with its line
// memory read and the window taps, and its RGB word then sits in an
// output register. Results trail the input by one row plus one pixel, so
// a frame must be followed by image_width+1 flush words to drain it; the
// result flagged end_of_frame rearms the block for the next frame. Missing
// colors are the truncated mean of the 2 or 4 neighbours; pixels outside
// the frame count as zero. Width and height (clamped to [2, MAX]) must be
// written only while idle; the block itself does not enforce this. The
// line memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_debayer_gbrg
  import bdb_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [0:0]           command_i,
  input  wire logic [PixW-1:0]      raw_pixel_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [PixW-1:0]      red_o,
  output logic      [PixW-1:0]      green_o,
  output logic      [PixW-1:0]      blue_o,
  output logic      [0:0]           end_of_row_o,
  output logic      [0:0]           end_of_frame_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          accept;
  logic [CW-1:0] rd_addr;
  site_t         site;

  logic            s1_v_q;
  logic [PixW-1:0] s1_sample_q;
  site_t           s1_site_q;
  logic [CW-1:0]   s1_addr_q;
  logic            s1_adv;
  logic            out_load;

  logic [2*PixW-1:0] ls_rd;
  logic [PixW-1:0]   older, newer;
  logic [PixW-1:0]   red, green, blue;

  logic            out_v_q;
  logic [PixW-1:0] red_q, green_q, blue_q;
  logic            eor_q, eof_q;

  assign s1_adv     = s1_v_q && (!s1_site_q.emit || !out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = s1_adv && s1_site_q.emit;

  bdb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .rd_addr_o  (rd_addr),
    .site_o     (site)
  );

  bdb_line_store #(
    .Depth(MAX_WIDTH),
    .DataW(2 * PixW)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(rd_addr),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_addr_q),
    .wr_data_i({newer, s1_sample_q}),
    .rd_data_o(ls_rd)
  );

  assign older = ls_rd[2*PixW-1:PixW];
  assign newer = ls_rd[PixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= (command_i == CMD_FLUSH) ? '0 : raw_pixel_i;
      s1_site_q   <= site;
      s1_addr_q   <= rd_addr;
    end
  end

  bdb_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .col_top_i(older),
    .col_mid_i(newer),
    .col_bot_i(s1_sample_q),
    .site_i   (s1_site_q),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      eor_q   <= s1_site_q.last_col;
      eof_q   <= s1_site_q.last_col && s1_site_q.last_row;
    end
  end

  assign out_valid_o    = out_v_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

`ifndef NO_ASSERTIONS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_site_q.emit && out_v_q && !out_ready_i)
      |=> (s1_v_q && $stable(s1_addr_q)))
    else $error("window stage lost its word under output stall");

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!end_of_frame_o || end_of_row_o))
    else $error("end of frame without end of row");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_v_q && !out_v_q) |=> !out_v_q)
    else $error("result appeared with an empty pipeline");

  a_mem_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_v_q) |-> s1_adv)
    else $error("new word read while window stage holds");
`endif

endmodule

`default_nettype wire

/* rtl/bdb_line_store.sv */
// ----------------------------------------------------------------------------
// bdb_line_store
// two-row line memory with registered read and write-to-read bypass
// ----------------------------------------------------------------------------
`default_nettype none

module bdb_line_store
  import bdb_pkg::*;
#(
  parameter int Depth = MaxWidthDef,
  parameter int DataW = 2 * PixW
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [DataW-1:0]         wr_data_i,
  output logic      [DataW-1:0]         rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // same-address write in the read cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

/* rtl/bdb_ctrl.sv */
// ----------------------------------------------------------------------------
// bdb_ctrl
// size registers, input and output position counters, site flags
// ----------------------------------------------------------------------------
`default_nettype none

module bdb_ctrl
  import bdb_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CfgIndexW-1:0]         cfg_index_i,
  input  wire logic [CfgW-1:0]              cfg_data_i,
  input  wire logic                         accept_i,
  output logic      [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output site_t                             site_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CfgW-1:0] cfg_w_q, cfg_h_q;
  logic [WW-1:0]   w_lim, w_m1;
  logic [HW-1:0]   h_lim, h_m1;

  logic [CW-1:0] in_col_q, in_col_d;
  logic          in_row_nz_q, in_row_nz_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic          pend_q, pend_d;

  logic in_wrap, pend_now, last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= DimReset;
      cfg_h_q <= DimReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp to [2, max]
  always_comb begin
    if (cfg_w_q < CfgW'(2)) begin
      w_lim = WW'(2);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(cfg_w_q);
    end
    if (cfg_h_q < CfgW'(2)) begin
      h_lim = HW'(2);
    end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(cfg_h_q);
    end
  end

  assign w_m1 = w_lim - WW'(1);
  assign h_m1 = h_lim - HW'(1);

  assign in_wrap  = WW'(in_col_q) >= w_m1;
  assign pend_now = pend_q || (in_row_nz_q && (in_col_q != '0));
  assign last_col = WW'(out_col_q) >= w_m1;
  assign last_row = HW'(out_row_q) >= h_m1;

  assign rd_addr_o = in_col_q;

  always_comb begin
    site_o.emit      = pend_now;
    site_o.col0      = (in_col_q == '0);
    site_o.x_odd     = out_col_q[0];
    site_o.y_odd     = out_row_q[0];
    site_o.first_col = (out_col_q == '0);
    site_o.last_col  = last_col;
    site_o.first_row = (out_row_q == '0);
    site_o.last_row  = last_row;
  end

  always_comb begin
    in_col_d    = in_wrap ? '0 : in_col_q + CW'(1);
    in_row_nz_d = in_row_nz_q || in_wrap;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    pend_d      = pend_now;
    if (pend_now) begin
      if (last_col && last_row) begin
        out_col_d   = '0;
        out_row_d   = '0;
        in_col_d    = '0;
        in_row_nz_d = 1'b0;
        pend_d      = 1'b0;
      end else if (last_col) begin
        out_col_d = '0;
        out_row_d = out_row_q + RW'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_nz_q <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      pend_q      <= 1'b0;
    end else if (accept_i) begin
      in_col_q    <= in_col_d;
      in_row_nz_q <= in_row_nz_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      pend_q      <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/bdb_window.sv */
// ----------------------------------------------------------------------------
// bdb_window
// 3x3 window taps, edge masking and bilinear color interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module bdb_window
  import bdb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic [PixW-1:0] col_top_i,
  input  wire logic [PixW-1:0] col_mid_i,
  input  wire logic [PixW-1:0] col_bot_i,
  input  wire site_t           site_i,
  output logic      [PixW-1:0] red_o,
  output logic      [PixW-1:0] green_o,
  output logic      [PixW-1:0] blue_o
);

  logic [PixW-1:0] lt_q [3];
  logic [PixW-1:0] ct_q [3];
  logic [PixW-1:0] col_new [3];
  logic [PixW-1:0] wl [3];
  logic [PixW-1:0] wc [3];
  logic [PixW-1:0] wr [3];
  logic [PixW:0]   hsum, vsum;
  logic [PixW+1:0] csum, dsum;
  logic [PixW-1:0] h_avg, v_avg, cross_avg, diag;

  assign col_new[0] = col_top_i;
  assign col_new[1] = col_mid_i;
  assign col_new[2] = col_bot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        lt_q[r] <= '0;
        ct_q[r] <= '0;
      end
    end else if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        lt_q[r] <= site_i.col0 ? '0 : ct_q[r];
        ct_q[r] <= col_new[r];
      end
    end
  end

  // out-of-frame neighbours read as zero
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wl[r] = site_i.first_col ? '0 : lt_q[r];
      wc[r] = ct_q[r];
      wr[r] = (site_i.last_col || site_i.col0) ? '0 : col_new[r];
    end
    if (site_i.first_row) begin
      wl[0] = '0;
      wc[0] = '0;
      wr[0] = '0;
    end
    if (site_i.last_row) begin
      wl[2] = '0;
      wc[2] = '0;
      wr[2] = '0;
    end
  end

  assign hsum      = {1'b0, wl[1]} + {1'b0, wr[1]};
  assign vsum      = {1'b0, wc[0]} + {1'b0, wc[2]};
  assign csum      = {1'b0, hsum} + {1'b0, vsum};
  assign dsum      = {2'b00, wl[0]} + {2'b00, wr[0]} + {2'b00, wl[2]} + {2'b00, wr[2]};
  assign h_avg     = hsum[PixW:1];
  assign v_avg     = vsum[PixW:1];
  assign cross_avg = csum[PixW+1:2];
  assign diag      = dsum[PixW+1:2];

  always_comb begin
    case ({site_i.y_odd, site_i.x_odd})
      2'b00: begin
        green_o = wc[1];
        blue_o  = h_avg;
        red_o   = v_avg;
      end
      2'b01: begin
        blue_o  = wc[1];
        green_o = cross_avg;
        red_o   = diag;
      end
      2'b10: begin
        red_o   = wc[1];
        green_o = cross_avg;
        blue_o  = diag;
      end
      default: begin
        green_o = wc[1];
        blue_o  = v_avg;
        red_o   = h_avg;
      end
    endcase
  end

endmodule

`default_nettype wire

/* test/bilinear_debayer_gbrg_check.sv */
// ----------------------------------------------------------------------------
// bilinear_debayer_gbrg_check
// predicts and checks the rgb words of the gbrg bilinear demosaic block
// ----------------------------------------------------------------------------
// Watches the register port and both word channels. Every accepted Bayer word
// runs through a local demosaic predictor that keeps its own line stores,
// 3x3 window, positions and dimension registers. A predicted rgb word is
// queued, and each rgb word the block hands out is compared field by field
// with the oldest queued one. Mismatches and the number of words still
// awaited go back to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_debayer_gbrg_check
  import bdb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic [0:0]           command_i,
  input  wire logic [PixW-1:0]      raw_pixel_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [PixW-1:0]      red_i,
  input  wire logic [PixW-1:0]      green_i,
  input  wire logic [PixW-1:0]      blue_i,
  input  wire logic [0:0]           end_of_row_i,
  input  wire logic [0:0]           end_of_frame_i,
  output int                        mismatches_o,
  output int                        awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic            end_of_row;
    logic            end_of_frame;
  } rgb_word_t;

  int unsigned     width_cfg;
  int unsigned     height_cfg;
  bit [PixW-1:0]   row_older [MaxWidthDef];
  bit [PixW-1:0]   row_newer [MaxWidthDef];
  bit [PixW-1:0]   taps [3][3];
  int              in_col;
  int              in_row;
  int              out_col;
  int              out_row;
  bit              primed;
  rgb_word_t       rgb_expected [$];
  rgb_word_t       rgb_seen;
  rgb_word_t       rgb_want;

  function automatic int clamp_dim(input int unsigned v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic string rgb_text(input rgb_word_t word);
    return $sformatf("r %h g %h b %h eor %b eof %b", word.red, word.green, word.blue,
                     word.end_of_row, word.end_of_frame);
  endfunction

  // taps and win are indexed [column][row]: left/mid/right, top/mid/bottom
  task automatic predict_rgb(input logic cmd, input logic [PixW-1:0] pix);
    int            w;
    int            h;
    int            c;
    int            r;
    int            idx;
    int            x;
    int            y;
    int            left;
    int            right;
    int            up;
    int            down;
    int            cross_avg;
    int            diag_avg;
    bit [PixW-1:0] sample;
    bit [PixW-1:0] fresh [3];
    bit [PixW-1:0] win [3][3];
    bit            last_col;
    bit            last;
    rgb_word_t     word;

    w = clamp_dim(width_cfg, MaxWidthDef);
    h = clamp_dim(height_cfg, MaxHeightDef);
    sample = (cmd == CMD_FLUSH) ? '0 : pix;
    c = in_col;
    r = in_row;
    idx = (c < MaxWidthDef) ? c : 0;

    fresh[0] = row_older[idx];
    fresh[1] = row_newer[idx];
    fresh[2] = sample;
    row_older[idx] = fresh[1];
    row_newer[idx] = sample;

    for (int i = 0; i < 3; i++) begin
      if (c == 0) begin
        // site at the end of the previous row, right column outside
        win[0][i] = taps[1][i];
        win[1][i] = taps[2][i];
        win[2][i] = '0;
        taps[0][i] = '0;
        taps[1][i] = '0;
      end else begin
        taps[0][i] = taps[1][i];
        taps[1][i] = taps[2][i];
      end
      taps[2][i] = fresh[i];
    end
    if (c != 0) win = taps;

    if (c >= w - 1) begin
      in_col = 0;
      in_row = in_row + 1;
    end else begin
      in_col = c + 1;
    end

    if (!primed && r >= 1 && c >= 1) primed = 1'b1;
    if (!primed) return;

    x = out_col;
    y = out_row;
    last_col = (x >= w - 1);
    last = last_col && (y >= h - 1);

    for (int i = 0; i < 3; i++) begin
      if (x == 0) win[0][i] = '0;
      if (x + 1 >= w) win[2][i] = '0;
      if (y == 0) win[i][0] = '0;
      if (y + 1 >= h) win[i][2] = '0;
    end

    left = int'(win[0][1]);
    right = int'(win[2][1]);
    up = int'(win[1][0]);
    down = int'(win[1][2]);
    cross_avg = (left + right + up + down) >> 2;
    diag_avg = (int'(win[0][0]) + int'(win[2][0]) + int'(win[0][2]) + int'(win[2][2])) >> 2;

    if (y % 2 == 0) begin
      if (x % 2 == 0) begin
        word.green = win[1][1];
        word.blue = 8'((left + right) >> 1);
        word.red = 8'((up + down) >> 1);
      end else begin
        word.blue = win[1][1];
        word.green = 8'(cross_avg);
        word.red = 8'(diag_avg);
      end
    end else begin
      if (x % 2 == 0) begin
        word.red = win[1][1];
        word.green = 8'(cross_avg);
        word.blue = 8'(diag_avg);
      end else begin
        word.green = win[1][1];
        word.blue = 8'((up + down) >> 1);
        word.red = 8'((left + right) >> 1);
      end
    end
    word.end_of_row = last_col;
    word.end_of_frame = last;
    rgb_expected.push_back(word);

    if (last) begin
      out_col = 0;
      out_row = 0;
      in_col = 0;
      in_row = 0;
      primed = 1'b0;
    end else if (last_col) begin
      out_col = 0;
      out_row = y + 1;
    end else begin
      out_col = x + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg = 32'(DimReset);
      height_cfg = 32'(DimReset);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) taps[i][j] = '0;
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      primed = 1'b0;
      rgb_expected.delete();
      mismatches_o = 0;
      awaited_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        rgb_seen = {red_i, green_i, blue_i, end_of_row_i, end_of_frame_i};
        if (rgb_expected.size() == 0) begin
          $display("%0t: rgb word with none expected, got %s", $time, rgb_text(rgb_seen));
          mismatches_o++;
        end else begin
          rgb_want = rgb_expected.pop_front();
          if (rgb_seen !== rgb_want) begin
            $display("%0t: rgb word mismatch, expected %s, got %s", $time,
                     rgb_text(rgb_want), rgb_text(rgb_seen));
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) width_cfg = 32'(cfg_data_i);
        else if (cfg_index_i == REG_IMAGE_HEIGHT) height_cfg = 32'(cfg_data_i);
      end
      if (in_valid_i && in_ready_i) predict_rgb(command_i, raw_pixel_i);
      awaited_o = rgb_expected.size();
    end
  end

endmodule

`default_nettype wire

/* test/bilinear_debayer_gbrg_test.sv */
// ----------------------------------------------------------------------------
// bilinear_debayer_gbrg_test
// stimulus and verdict for the gbrg bilinear demosaic block
// ----------------------------------------------------------------------------
// Sends Bayer frames, each followed by its width+1 flush words, under several
// frame sizes written between frames while the block is idle: first a few
// hand-picked 2x2 (clamped) and 2x3 frames, full-scale samples, a
// flush inside the frame and a pixel inside the flush tail, then random
// small frames with random content, some with short or long flush tails.
// Sender and receiver stall at random.
// The checker beside the block predicts and compares every rgb word.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_debayer_gbrg_test;
  import bdb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 1600;
  localparam int QuietLimit  = 2000;
  localparam int SettleCycles = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CfgW-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [0:0]           command = CMD_PIXEL;
  logic [PixW-1:0]      raw_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PixW-1:0]      red;
  logic [PixW-1:0]      green;
  logic [PixW-1:0]      blue;
  logic [0:0]           end_of_row;
  logic [0:0]           end_of_frame;
  int                   mismatches;
  int                   words_awaited;

  int                   send_idle_pct = 8;
  int                   recv_idle_pct = 66;
  int                   random_words;

  bilinear_debayer_gbrg dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .raw_pixel_i    (raw_pixel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .end_of_row_o   (end_of_row),
    .end_of_frame_o (end_of_frame)
  );

  bilinear_debayer_gbrg_check rgb_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .command_i      (command),
    .raw_pixel_i    (raw_pixel),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .end_of_row_i   (end_of_row),
    .end_of_frame_i (end_of_frame),
    .mismatches_o   (mismatches),
    .awaited_o      (words_awaited)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // starts and ends at a falling edge
  task automatic send_word(input cmd_e cmd, input logic [PixW-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    raw_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_dims(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    in_valid <= 1'b0;
    while (words_awaited != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random frames; the tail is padded so the run ends on a frame boundary
  task automatic run_frames(input int w_cfg, input int h_cfg, input int frames);
    int w;
    int h;
    int span;
    int sent;
    int tail;
    int pad;

    w = (w_cfg < 2) ? 2 : (w_cfg > MaxWidthDef) ? MaxWidthDef : w_cfg;
    h = (h_cfg < 2) ? 2 : (h_cfg > MaxHeightDef) ? MaxHeightDef : h_cfg;
    span = w * h + w + 1;
    sent = 0;
    write_dims(CfgW'(w_cfg), CfgW'(h_cfg));
    repeat (frames) begin
      repeat (w * h) begin
        if ($urandom_range(99) < 5) send_word(CMD_FLUSH, PixW'($urandom));
        else send_word(CMD_PIXEL, PixW'($urandom));
      end
      tail = ($urandom_range(99) < 15) ? $urandom_range(2 * w + 2) : w + 1;
      repeat (tail) begin
        if ($urandom_range(99) < 10) send_word(CMD_PIXEL, PixW'($urandom));
        else send_word(CMD_FLUSH, PixW'($urandom));
      end
      sent += w * h + tail;
    end
    pad = (span - sent % span) % span;
    repeat (pad) send_word(CMD_FLUSH, PixW'($urandom));
    random_words += sent + pad;
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL bilinear_debayer_gbrg");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // 2x2 after clamping from below
    write_dims(CfgW'(0), CfgW'(1));
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_FLUSH, 8'h00);
    send_word(CMD_PIXEL, 8'hAA);
    send_word(CMD_FLUSH, 8'h55);
    // flush inside the frame reads as zero
    send_word(CMD_PIXEL, 8'h80);
    send_word(CMD_FLUSH, 8'hFF);
    send_word(CMD_PIXEL, 8'h7F);
    send_word(CMD_PIXEL, 8'h01);
    send_word(CMD_FLUSH, 8'h00);
    send_word(CMD_FLUSH, 8'h00);
    send_word(CMD_FLUSH, 8'h00);

    write_dims(CfgW'(2), CfgW'(3));
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_FLUSH, 8'h00);
    send_word(CMD_FLUSH, 8'h00);
    send_word(CMD_FLUSH, 8'h00);

    random_words = 0;
    while (random_words < RandomWords) begin
      if (random_words < RandomWords / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 66;
      end else if (random_words < 2 * RandomWords / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(7) == 0) begin
        run_frames($urandom_range(11, 40), $urandom_range(2, 4), $urandom_range(1, 2));
      end else begin
        run_frames($urandom_range(2, 10), $urandom_range(2, 6), $urandom_range(1, 3));
      end
    end

    in_valid <= 1'b0;
    while (words_awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && words_awaited == 0) begin
      $display("PASS bilinear_debayer_gbrg");
    end else begin
      $display("FAIL bilinear_debayer_gbrg");
    end
    $finish;
  end

endmodule

`default_nettype wire
